### rtl/ple_pkg.sv
package ple_pkg;

  // Largest list the cell chain supports; sets the width of slot numbers.
  localparam int MAX_CAPACITY = 64;
  localparam int DEF_CAPACITY = 16;
  localparam int SLOT_W       = $clog2(MAX_CAPACITY);
  localparam int DATA_W       = 32;

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_AT    = 3'd2,
    ACT_DEL_AT    = 3'd3,
    ACT_SEARCH    = 3'd4,
    ACT_REVERSE   = 3'd5,
    ACT_READ      = 3'd6,
    ACT_UNUSED    = 3'd7
  } act_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_MISSING = 3'd3,
    ST_FULL    = 3'd4,
    ST_NOREV   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  // Broadcast to every cell of the chain in each cycle.
  typedef struct packed {
    cell_op_t            op;
    logic [SLOT_W-1:0]   slot;
    logic [DATA_W-1:0]   value;
  } cell_cmd_t;

endpackage

### rtl/ple_cell.sv
module ple_cell #(
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  ple_pkg::cell_cmd_t       cmd,
  input  logic [ple_pkg::DATA_W-1:0] left_data,
  input  logic [ple_pkg::DATA_W-1:0] right_data,
  input  logic [ple_pkg::DATA_W-1:0] head_data,
  output logic [ple_pkg::DATA_W-1:0] data_r,
  output logic                     match_r
);
  import ple_pkg::*;

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      CELL_HOLD: data_nxt = data_r;
      CELL_INSERT: begin
        if (MY_SLOT == cmd.slot) data_nxt = cmd.value;
        else if (MY_SLOT > cmd.slot) data_nxt = left_data;
      end
      CELL_REMOVE: begin
        if (MY_SLOT >= cmd.slot) data_nxt = right_data;
      end
      CELL_ROTATE: begin
        if (MY_SLOT < cmd.slot) data_nxt = right_data;
        else if (MY_SLOT == cmd.slot) data_nxt = head_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  // Compare against the key every cycle; the engine reads it after a search.
  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= (data_r == cmd.value);
  end

endmodule

### rtl/ple_find.sv
module ple_find #(
  parameter int CAPACITY = 16
) (
  input  logic [CAPACITY-1:0]           match,
  input  logic [$clog2(CAPACITY+1)-1:0] occ,
  output logic                          found,
  output logic [$clog2(CAPACITY)-1:0]   idx
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int OCC_W = $clog2(CAPACITY+1);

  logic [CAPACITY-1:0] hit;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit[i] = match[i] && (OCC_W'(i) < occ);
    end
  end

  // Lowest occupied slot that matches wins.
  always_comb begin
    found = |hit;
    idx   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit[i]) idx = IDX_W'(i);
    end
  end

endmodule

### rtl/positional_list_engine.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_ready    action, value, position
// out_     output     out_valid/out_ready  status, found_position, element,
//                                          length, final_item
//
// Insert, delete and single-result failures: result registered at accept.
// Search: cell compare registered at accept, then first-match encode across the chain into the output register.
// Reverse: partial rotations of the cell chain after accept, from the last slot down to slot 1.
// Readout: elements are emitted in order as out_ready allows; the chain rotates once per item.
// Reset (rst_n low, synchronous) empties the list; cell contents stay undefined.
// A new item is taken only when idle and the output register is free or draining.

module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::DEF_CAPACITY
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_action,
  input  logic signed [31:0]           in_value,
  input  logic [7:0]                   in_position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_status,
  output logic [4:0]                   out_found_position,
  output logic signed [31:0]           out_element,
  output logic [4:0]                   out_length,
  output logic                         out_final_item
);
  import ple_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int OCC_W = $clog2(CAPACITY+1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FIND = 4'b0010,
    S_REV  = 4'b0100,
    S_READ = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [4:0]         out_fpos_r, out_fpos_nxt;
  logic [DATA_W-1:0]  out_elem_r, out_elem_nxt;
  logic [4:0]         out_len_r, out_len_nxt;
  logic               out_final_r, out_final_nxt;

  cell_cmd_t          cmd;
  logic [DATA_W-1:0]  cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  logic               find_hit;
  logic [IDX_W-1:0]   find_idx;

  logic               out_free;
  logic               accept;
  logic [8:0]         pos_x;
  logic [8:0]         occ_x;
  logic [IDX_W-1:0]   last_idx;

  // ---------------------------------------------------------------------------
  // Cell chain: cell 0 is the head of the list
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ple_cell #(
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_data  ((g == 0) ? cmd.value : cell_data[(g == 0) ? 0 : g - 1]),
      .right_data (cell_data[(g == CAPACITY - 1) ? g : g + 1]),
      .head_data  (cell_data[0]),
      .data_r     (cell_data[g]),
      .match_r    (cell_match[g])
    );
  end

  ple_find #(
    .CAPACITY (CAPACITY)
  ) u_find (
    .match (cell_match),
    .occ   (occ_r),
    .found (find_hit),
    .idx   (find_idx)
  );

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign pos_x    = 9'(in_position);
  assign occ_x    = 9'(occ_r);
  assign last_idx = IDX_W'(occ_r - OCC_W'(1));

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    cmd.op        = CELL_HOLD;
    cmd.slot      = '0;
    cmd.value     = in_value;

    // drop the result once taken
    out_valid_nxt = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_fpos_nxt  = out_fpos_r;
    out_elem_nxt  = out_elem_r;
    out_len_nxt   = out_len_r;
    out_final_nxt = out_final_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_status_nxt = ST_OK;
          out_fpos_nxt   = '0;
          out_elem_nxt   = '0;
          out_final_nxt  = 1'b1;
          out_valid_nxt  = 1'b1;
          unique case (act_t'(in_action))
            ACT_INS_FRONT, ACT_INS_BACK: begin
              if (occ_r == OCC_FULL) begin
                out_status_nxt = ST_FULL;
              end else begin
                cmd.op   = CELL_INSERT;
                cmd.slot = (act_t'(in_action) == ACT_INS_FRONT) ? '0 : SLOT_W'(occ_r);
                occ_nxt  = occ_r + OCC_W'(1);
              end
            end
            ACT_INS_AT: begin
              if (pos_x == 9'd0 || pos_x > occ_x + 9'd1) begin
                out_status_nxt = ST_RANGE;
              end else if (occ_r == OCC_FULL) begin
                out_status_nxt = ST_FULL;
              end else begin
                cmd.op   = CELL_INSERT;
                cmd.slot = SLOT_W'(pos_x - 9'd1);
                occ_nxt  = occ_r + OCC_W'(1);
              end
            end
            ACT_DEL_AT: begin
              if (occ_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else if (pos_x == 9'd0 || pos_x > occ_x) begin
                out_status_nxt = ST_RANGE;
              end else begin
                cmd.op   = CELL_REMOVE;
                cmd.slot = SLOT_W'(pos_x - 9'd1);
                occ_nxt  = occ_r - OCC_W'(1);
              end
            end
            ACT_SEARCH: begin
              if (occ_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                // cells latch their compare at this edge; encode next cycle
                out_valid_nxt = 1'b0;
                state_nxt     = S_FIND;
              end
            end
            ACT_REVERSE: begin
              if (occ_r <= OCC_W'(1)) begin
                out_status_nxt = ST_NOREV;
              end else begin
                cnt_nxt   = last_idx;
                state_nxt = S_REV;
              end
            end
            ACT_READ: begin
              if (occ_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                cnt_nxt       = '0;
                state_nxt     = S_READ;
              end
            end
            default: out_status_nxt = ST_RANGE;
          endcase
          out_len_nxt = 5'(occ_nxt);
        end
      end

      S_FIND: begin
        out_valid_nxt  = 1'b1;
        out_final_nxt  = 1'b1;
        out_elem_nxt   = '0;
        out_len_nxt    = 5'(occ_r);
        out_status_nxt = find_hit ? ST_OK : ST_MISSING;
        out_fpos_nxt   = find_hit ? 5'(OCC_W'(find_idx) + OCC_W'(1)) : 5'd0;
        state_nxt      = S_IDLE;
      end

      S_REV: begin
        // rotate the head into the shrinking tail window
        cmd.op   = CELL_ROTATE;
        cmd.slot = SLOT_W'(cnt_r);
        cnt_nxt  = cnt_r - IDX_W'(1);
        if (cnt_r == IDX_W'(1)) state_nxt = S_IDLE;
      end

      S_READ: begin
        if (out_free) begin
          // emit the head, then rotate the whole list by one
          cmd.op         = CELL_ROTATE;
          cmd.slot       = SLOT_W'(last_idx);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_fpos_nxt   = '0;
          out_elem_nxt   = cell_data[0];
          out_len_nxt    = 5'(occ_r);
          out_final_nxt  = (cnt_r == last_idx);
          cnt_nxt        = cnt_r + IDX_W'(1);
          if (cnt_r == last_idx) state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload of the output register: no reset needed.
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_fpos_r   <= out_fpos_nxt;
    out_elem_r   <= out_elem_nxt;
    out_len_r    <= out_len_nxt;
    out_final_r  <= out_final_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_fpos_r;
  assign out_element        = out_elem_r;
  assign out_length         = out_len_r;
  assign out_final_item     = out_final_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_FULL)
    else $error("occupancy above capacity");

  a_find_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND) |-> !out_valid_r)
    else $error("output register busy while a search result is pending");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid_r || state_r == S_FIND || state_r == S_READ))
    else $error("accepted item produced no result and no pending work");

  a_occ_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(occ_r))
    else $error("occupancy changed without an accepted item");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import ple_pkg::*;

  localparam int CAP         = DEF_CAPACITY;
  localparam int STALL_LIMIT = 4000;
  localparam int REPORT_MAX  = 10;

  // One result item as the block should present it.
  typedef struct packed {
    logic [2:0]         status;
    logic [4:0]         found_pos;
    logic signed [31:0] element;
    logic [4:0]         length;
    logic               final_item;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_action;
  logic signed [31:0] in_value;
  logic [7:0]         in_position;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_status;
  logic [4:0]         out_found_position;
  logic signed [31:0] out_element;
  logic [4:0]         out_length;
  logic               out_final_item;

  // Mirror of the list contents, front of the list at index 0.
  logic signed [31:0] list_mirror[$];
  list_result_t       pending_results[$];

  int src_idle_pct;
  int snk_idle_pct;
  bit fill_mode;
  int mismatch_cnt;
  int request_cnt;
  int result_cnt;
  int longest_list;
  int stall_cnt;
  int act_seen[8];

  positional_list_engine #(.CAPACITY(CAP)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_found_position(out_found_position),
    .out_element       (out_element),
    .out_length        (out_length),
    .out_final_item    (out_final_item)
  );

  always #10 clk = ~clk;

  // Queue one expected result; length is the list size after the request.
  function automatic void note_result(status_t st, logic [4:0] fpos,
                                      logic signed [31:0] elem, logic fin);
    list_result_t r;
    r.status     = st;
    r.found_pos  = fpos;
    r.element    = elem;
    r.length     = 5'(list_mirror.size());
    r.final_item = fin;
    pending_results.push_back(r);
  endfunction

  // Apply one accepted request to the mirror and queue what it must produce.
  function automatic void apply_request(act_t act, logic signed [31:0] val,
                                        logic [7:0] pos);
    int len;
    int hit;
    int p;
    logic signed [31:0] tmp;
    len = list_mirror.size();
    p   = int'(pos);
    hit = 0;
    act_seen[int'(act)]++;
    request_cnt++;
    case (act)
      ACT_INS_FRONT, ACT_INS_BACK: begin
        if (len >= CAP) begin
          note_result(ST_FULL, 5'd0, 32'sd0, 1'b1);
        end else begin
          if (act == ACT_INS_FRONT) list_mirror.push_front(val);
          else list_mirror.push_back(val);
          note_result(ST_OK, 5'd0, 32'sd0, 1'b1);
        end
      end
      ACT_INS_AT: begin
        // Position is judged before fullness.
        if (p < 1 || p > len + 1) begin
          note_result(ST_RANGE, 5'd0, 32'sd0, 1'b1);
        end else if (len >= CAP) begin
          note_result(ST_FULL, 5'd0, 32'sd0, 1'b1);
        end else begin
          list_mirror.insert(p - 1, val);
          note_result(ST_OK, 5'd0, 32'sd0, 1'b1);
        end
      end
      ACT_DEL_AT: begin
        if (len == 0) begin
          note_result(ST_EMPTY, 5'd0, 32'sd0, 1'b1);
        end else if (p < 1 || p > len) begin
          // No wrap around the circle past the tail.
          note_result(ST_RANGE, 5'd0, 32'sd0, 1'b1);
        end else begin
          list_mirror.delete(p - 1);
          note_result(ST_OK, 5'd0, 32'sd0, 1'b1);
        end
      end
      ACT_SEARCH: begin
        if (len == 0) begin
          note_result(ST_EMPTY, 5'd0, 32'sd0, 1'b1);
        end else begin
          for (int i = 0; i < len; i++)
            if (hit == 0 && list_mirror[i] == val) hit = i + 1;
          if (hit != 0) note_result(ST_OK, 5'(hit), 32'sd0, 1'b1);
          else note_result(ST_MISSING, 5'd0, 32'sd0, 1'b1);
        end
      end
      ACT_REVERSE: begin
        if (len <= 1) begin
          note_result(ST_NOREV, 5'd0, 32'sd0, 1'b1);
        end else begin
          for (int i = 0; i < len / 2; i++) begin
            tmp                    = list_mirror[i];
            list_mirror[i]         = list_mirror[len - 1 - i];
            list_mirror[len - 1 - i] = tmp;
          end
          note_result(ST_OK, 5'd0, 32'sd0, 1'b1);
        end
      end
      ACT_READ: begin
        if (len == 0) begin
          note_result(ST_EMPTY, 5'd0, 32'sd0, 1'b1);
        end else begin
          for (int i = 0; i < len; i++)
            note_result(ST_OK, 5'd0, list_mirror[i], (i == len - 1));
        end
      end
      default: note_result(ST_RANGE, 5'd0, 32'sd0, 1'b1);
    endcase
    if (list_mirror.size() > longest_list) longest_list = list_mirror.size();
  endfunction

  // Drive one item at the falling edge, hold it until accepted, then predict.
  task automatic send_item(act_t act, logic signed [31:0] val, logic [7:0] pos);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_value    <= val;
    in_position <= pos;
    do @(posedge clk); while (!in_ready);
    apply_request(act, val, pos);
  endtask

  // Drop valid and hold off until every expected result has drained.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    int len;
    len = list_mirror.size();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd0;
      3: return -32'sd1;
      4, 5: begin
        // Reuse a stored value so searches hit and duplicates appear.
        if (len != 0) return list_mirror[$urandom_range(len - 1)];
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_position();
    int len;
    len = list_mirror.size();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'($urandom_range(255));
      2: return 8'(len + 1);
      3: return 8'(len + 2);
      default: return 8'($urandom_range(len + 1, 1));
    endcase
  endfunction

  // Walk the list up to full and back down to empty, with noise on the way.
  task automatic random_item();
    int   len;
    int   r;
    act_t act;
    len = list_mirror.size();
    if (len >= CAP && $urandom_range(9) < 3) fill_mode = 1'b0;
    if (len == 0 && $urandom_range(9) < 4) fill_mode = 1'b1;
    r = $urandom_range(99);
    if (fill_mode) begin
      if (r < 25) act = ACT_INS_FRONT;
      else if (r < 45) act = ACT_INS_BACK;
      else if (r < 60) act = ACT_INS_AT;
      else if (r < 70) act = ACT_DEL_AT;
      else if (r < 80) act = ACT_SEARCH;
      else if (r < 86) act = ACT_REVERSE;
      else if (r < 97) act = ACT_READ;
      else act = ACT_UNUSED;
    end else begin
      if (r < 8) act = ACT_INS_FRONT;
      else if (r < 16) act = ACT_INS_BACK;
      else if (r < 24) act = ACT_INS_AT;
      else if (r < 55) act = ACT_DEL_AT;
      else if (r < 70) act = ACT_SEARCH;
      else if (r < 78) act = ACT_REVERSE;
      else if (r < 96) act = ACT_READ;
      else act = ACT_UNUSED;
    end
    send_item(act, pick_value(), pick_position());
  endtask

  // Empty-list failures, bounds of every position check, extreme values,
  // first match among duplicates, unused action code.
  task automatic test_directed();
    send_item(ACT_READ, 32'sd0, 8'd0);
    send_item(ACT_SEARCH, 32'sd5, 8'd0);
    send_item(ACT_DEL_AT, 32'sd0, 8'd1);
    send_item(ACT_REVERSE, 32'sd0, 8'd0);
    send_item(ACT_INS_AT, 32'sd9, 8'd0);
    send_item(ACT_INS_AT, 32'sd9, 8'd2);
    send_item(ACT_INS_AT, 32'sh7fff_ffff, 8'd1);
    send_item(ACT_REVERSE, 32'sd0, 8'd0);
    send_item(ACT_INS_FRONT, 32'sh8000_0000, 8'hff);
    send_item(ACT_INS_BACK, -32'sd1, 8'd0);
    send_item(ACT_INS_AT, 32'sd0, 8'd4);
    send_item(ACT_INS_AT, -32'sd1, 8'd2);
    send_item(ACT_SEARCH, -32'sd1, 8'd0);
    send_item(ACT_SEARCH, 32'sh1234_5678, 8'd0);
    send_item(ACT_SEARCH, 32'sd0, 8'd0);
    send_item(ACT_DEL_AT, 32'sd0, 8'd0);
    send_item(ACT_DEL_AT, 32'sd0, 8'd6);
    send_item(ACT_DEL_AT, 32'sd0, 8'hff);
    send_item(ACT_INS_AT, 32'sd1, 8'hff);
    send_item(ACT_UNUSED, 32'sh5a5a_a5a5, 8'haa);
    send_item(ACT_REVERSE, 32'sd0, 8'd0);
    send_item(ACT_READ, 32'sd0, 8'd0);
    send_item(ACT_DEL_AT, 32'sd0, 8'd1);
    send_item(ACT_DEL_AT, 32'sd0, 8'd4);
    send_item(ACT_READ, 32'sd0, 8'd0);
  endtask

  // Fill to capacity, then hit every full-list case and a full readout.
  task automatic test_capacity();
    int k;
    while (list_mirror.size() < CAP) begin
      k = $urandom_range(2);
      if (k == 0) send_item(ACT_INS_FRONT, $urandom, 8'd0);
      else if (k == 1) send_item(ACT_INS_BACK, $urandom, 8'd0);
      else send_item(ACT_INS_AT, $urandom,
                     8'($urandom_range(list_mirror.size() + 1, 1)));
    end
    send_item(ACT_INS_FRONT, 32'sd1, 8'd0);
    send_item(ACT_INS_BACK, 32'sd2, 8'd0);
    send_item(ACT_INS_AT, 32'sd3, 8'(CAP + 2));
    send_item(ACT_INS_AT, 32'sd3, 8'(CAP + 1));
    send_item(ACT_INS_AT, 32'sd3, 8'd1);
    send_item(ACT_SEARCH, list_mirror[CAP - 1], 8'd0);
    send_item(ACT_READ, 32'sd0, 8'd0);
    send_item(ACT_REVERSE, 32'sd0, 8'd0);
    send_item(ACT_READ, 32'sd0, 8'd0);
    send_item(ACT_DEL_AT, 32'sd0, 8'(CAP));
    send_item(ACT_DEL_AT, 32'sd0, 8'(CAP));
  endtask

  task automatic test_random(int n, int src_pct, int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (n) begin
      random_item();
      if ($urandom_range(49) == 0) wait_drained();
    end
  endtask

  // Receiver: stall at random at each falling edge.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= snk_idle_pct);

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      result_cnt++;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("unexpected result: status=%0d pos=%0d elem=%0d len=%0d fin=%0d",
                   out_status, out_found_position, out_element, out_length,
                   out_final_item);
      end else begin
        want = pending_results.pop_front();
        if (want.status !== out_status || want.found_pos !== out_found_position ||
            want.element !== out_element || want.length !== out_length ||
            want.final_item !== out_final_item) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX) begin
            $display("result %0d: exp status=%0d pos=%0d elem=%0d len=%0d fin=%0d",
                     result_cnt, want.status, want.found_pos, want.element,
                     want.length, want.final_item);
            $display("result %0d: got status=%0d pos=%0d elem=%0d len=%0d fin=%0d",
                     result_cnt, out_status, out_found_position, out_element,
                     out_length, out_final_item);
          end
        end
      end
    end
  end

  // Watchdog: end the run if no item moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_action    = ACT_INS_FRONT;
    in_value     = 32'sd0;
    in_position  = 8'd0;
    out_ready    = 1'b0;
    src_idle_pct = 7;
    snk_idle_pct = 85;
    fill_mode    = 1'b1;
    mismatch_cnt = 0;
    request_cnt  = 0;
    result_cnt   = 0;
    longest_list = 0;
    stall_cnt    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_capacity();
    wait_drained();
    test_random(40, 7, 85);
    test_random(40, 85, 7);
    test_random(40, 0, 0);

    // Let the last results drain, then allow for a trailing reverse.
    wait_drained();
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      mismatch_cnt += pending_results.size();
    end

    $display("ran %0d requests, checked %0d results, longest list %0d of %0d",
             request_cnt, result_cnt, longest_list, CAP);
    $display("inserts %0d/%0d/%0d, deletes %0d, searches %0d, reverses %0d, reads %0d",
             act_seen[ACT_INS_FRONT], act_seen[ACT_INS_BACK], act_seen[ACT_INS_AT],
             act_seen[ACT_DEL_AT], act_seen[ACT_SEARCH], act_seen[ACT_REVERSE],
             act_seen[ACT_READ]);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/ple_find.sv
rtl/positional_list_engine.sv
tb/tb.sv
